// ===== rtl/core/vector4_alu_normalise_unit_macros.svh =====
// Assertion macros for the vector ALU and normalise unit.
// Included by the top level; no other dependencies.
`ifndef VECTOR4_ALU_NORMALISE_UNIT_MACROS_SVH
`define VECTOR4_ALU_NORMALISE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VA4N_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VA4N_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VA4N_ASSERT(lbl, prop, msg)
`define VA4N_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/va4n_pkg.sv =====
// Shared types, codes and widths for the vector ALU and normalise unit.
// No dependencies.
package va4n_pkg;

  localparam int NUM_LANES   = 4;
  localparam int CMD_W       = 3;
  localparam int DIMS_W      = 3;
  localparam int COMP_W      = 16;
  localparam int SCALAR_W    = 34;
  localparam int STATUS_W    = 2;
  localparam int SQ_W        = 34;
  localparam int RAD_W       = SQ_W + 16;
  localparam int SQRT_STEPS  = RAD_W / 2;
  localparam int ROOT_W      = SQRT_STEPS;
  localparam int REM_W       = ROOT_W + 2;
  localparam int LEN_W       = ROOT_W;
  localparam int DIV_STEPS   = 15;
  localparam int Q_W         = DIV_STEPS;
  localparam int DREM_W      = LEN_W + 1;
  localparam int DIV_PRESHIFT = 7;
  localparam int LEN_FRAC_DROP = 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DOT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SQLEN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LEN   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NORM  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [COMP_W-1:0] val;
    logic              sat;
    logic [30:0]       aa;
    logic [31:0]       ab;
    logic [COMP_W-1:0] mag;
    logic              neg;
  } lane_res_t;

  typedef struct packed {
    logic [CMD_W-1:0]                  cmd;
    logic [NUM_LANES-1:0][COMP_W-1:0]  val;
    logic [NUM_LANES-1:0][COMP_W-1:0]  mag;
    logic [NUM_LANES-1:0]              neg;
    logic [SCALAR_W-1:0]               scalar;
    logic [STATUS_W-1:0]               status;
  } ctx_t;

endpackage

// ===== rtl/core/va4n_lane.sv =====
// One vector lane: saturating add/subtract, the two products and the magnitude.
// Depends on va4n_pkg.
module va4n_lane
  import va4n_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [CMD_W-1:0]  cmd,
  input  logic              active,
  input  logic [COMP_W-1:0] a,
  input  logic [COMP_W-1:0] b,
  output lane_res_t         res_r
);

  logic [COMP_W:0]   sum;
  logic              ovf;
  logic [COMP_W-1:0] clamp;
  logic [31:0]       prod_aa;
  logic [31:0]       prod_ab;
  lane_res_t         res_nxt;

  always_comb begin
    if (cmd == CMD_SUB) begin
      sum = {a[COMP_W-1], a} - {b[COMP_W-1], b};
    end else begin
      sum = {a[COMP_W-1], a} + {b[COMP_W-1], b};
    end
    ovf = sum[COMP_W] ^ sum[COMP_W-1];
    if (ovf) begin
      clamp = sum[COMP_W] ? 16'h8000 : 16'h7fff;
    end else begin
      clamp = sum[COMP_W-1:0];
    end
    prod_aa = 32'($signed(a) * $signed(a));
    prod_ab = 32'($signed(a) * $signed(b));
    res_nxt = '0;
    if (active) begin
      res_nxt.aa  = prod_aa[30:0];
      res_nxt.ab  = prod_ab;
      res_nxt.mag = a[COMP_W-1] ? (~a + 16'd1) : a;
      res_nxt.neg = a[COMP_W-1];
      if (cmd == CMD_ADD || cmd == CMD_SUB) begin
        res_nxt.val = clamp;
        res_nxt.sat = ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/core/va4n_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, of sq * 65536.
// Depends on va4n_pkg.
module va4n_sqrt
  import va4n_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   sq,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  n_r    [SQRT_STEPS];
  logic [REM_W-1:0]  rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_r [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    logic [RAD_W-1:0]  n_prev;
    logic [REM_W-1:0]  rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;
    logic [RAD_W-1:0]  n_nxt;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (s == 0) begin : g_first
      assign n_prev    = {sq, 16'd0};
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_next
      assign n_prev    = n_r[s-1];
      assign rem_prev  = rem_r[s-1];
      assign root_prev = root_r[s-1];
    end

    always_comb begin
      t     = {rem_prev, n_prev[RAD_W-1 -: 2]};
      trial = (REM_W+2)'({root_prev, 2'b01});
      n_nxt = {n_prev[RAD_W-3:0], 2'b00};
      if (t >= trial) begin
        rem_nxt  = REM_W'(t - trial);
        root_nxt = {root_prev[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = t[REM_W-1:0];
        root_nxt = {root_prev[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s]    <= n_nxt;
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
      end
    end
  end

  assign root = root_r[SQRT_STEPS-1];

endmodule

// ===== rtl/core/va4n_div.sv =====
// Pipelined restoring divider for one lane: (mag << 22) / len, one quotient bit per stage.
// Depends on va4n_pkg.
module va4n_div
  import va4n_pkg::*;
(
  input  logic                               clk,
  input  logic                               en,
  input  logic [COMP_W-1:0]                  mag,
  input  logic [DIV_STEPS-1:0][LEN_W-1:0]    len,
  output logic [Q_W-1:0]                     quo
);

  logic [DREM_W-1:0] rem_r [DIV_STEPS];
  logic [Q_W-1:0]    q_r   [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [DREM_W-1:0] rem_prev;
    logic [Q_W-1:0]    q_prev;
    logic [DREM_W:0]   t;
    logic [DREM_W-1:0] rem_nxt;
    logic [Q_W-1:0]    q_nxt;

    if (s == 0) begin : g_first
      // The low dividend bits are all zero, so only the top part is loaded.
      assign rem_prev = DREM_W'({mag, DIV_PRESHIFT'(0)});
      assign q_prev   = '0;
    end else begin : g_next
      assign rem_prev = rem_r[s-1];
      assign q_prev   = q_r[s-1];
    end

    always_comb begin
      t = {rem_prev, 1'b0};
      if (t >= (DREM_W+1)'(len[s])) begin
        rem_nxt = DREM_W'(t - (DREM_W+1)'(len[s]));
        q_nxt   = {q_prev[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = t[DREM_W-1:0];
        q_nxt   = {q_prev[Q_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        q_r[s]   <= q_nxt;
      end
    end
  end

  assign quo = q_r[DIV_STEPS-1];

endmodule

// ===== rtl/core/vector4_alu_normalise_unit.sv =====
// Pipeline: the lane and merge stages, followed by the 25-stage square root and the
// 15-stage per-lane divider.
// Throughput: one item per cycle; every stage advances together whenever the
// output register is empty or being taken.
// Reset: rst_n (synchronous, active low) clears all valid flags; data is not reset.
// Depends on va4n_pkg, va4n_lane, va4n_sqrt, va4n_div and the macros header.
`include "vector4_alu_normalise_unit_macros.svh"
module vector4_alu_normalise_unit
  import va4n_pkg::*;
#(
  parameter int LANES = 4
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // dims[2:0], a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (16 bits each), zero pad
  input  logic [135:0] in_tdata,
  // cmd[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z, out_w (16 bits each), scalar_out[97:64], zero pad
  output logic [103:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser
);

  localparam int LINE = SQRT_STEPS + DIV_STEPS;
  localparam int VLD  = LINE + 2;
  localparam logic [DIMS_W-1:0] LANES_D = DIMS_W'(LANES);

  logic                              adv;
  logic [VLD-1:0]                    vld_r;
  logic [VLD-1:0]                    vld_nxt;
  logic [DIMS_W-1:0]                 dims_c;
  logic [CMD_W-1:0]                  cmd_a_r;
  lane_res_t                         lane_a [NUM_LANES];
  ctx_t                              ctx_b_nxt;
  ctx_t                              ctx_b_r;
  logic [SQ_W-1:0]                   sq_b_nxt;
  logic [SQ_W-1:0]                   sq_b_r;
  ctx_t                              ctx_line_r [LINE];
  logic [ROOT_W-1:0]                 root;
  logic [DIV_STEPS-1:0][LEN_W-1:0]   len_in;
  logic [LEN_W-1:0]                  len_line_r [DIV_STEPS];
  logic [NUM_LANES-1:0][Q_W-1:0]     quo;
  ctx_t                              ctx_end;
  logic [LEN_W-1:0]                  len_end;
  logic [103:0]                      out_data_nxt;
  logic [1:0]                        out_user_nxt;
  logic [103:0]                      out_data_r;
  logic [1:0]                        out_user_r;
  logic                              out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    priority if (in_tdata[2:0] < 3'd2) begin
      dims_c = 3'd2;
    end else if (in_tdata[2:0] > LANES_D) begin
      dims_c = LANES_D;
    end else begin
      dims_c = in_tdata[2:0];
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    if (g < LANES) begin : g_on
      va4n_lane u_lane (
        .clk    (clk),
        .en     (adv),
        .cmd    (in_tuser),
        .active (DIMS_W'(g) < dims_c),
        .a      (in_tdata[3 + 16*g +: 16]),
        .b      (in_tdata[67 + 16*g +: 16]),
        .res_r  (lane_a[g])
      );
      va4n_div u_div (
        .clk (clk),
        .en  (adv),
        .mag (ctx_line_r[SQRT_STEPS-1].mag[g]),
        .len (len_in),
        .quo (quo[g])
      );
    end else begin : g_off
      assign lane_a[g] = '0;
      assign quo[g]    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_a_r <= in_tuser;
    end
  end

  // Merge stage: sums over the lanes and selection of the scalar result.
  always_comb begin
    logic [SCALAR_W-1:0] dot;
    logic                any_sat;
    dot      = '0;
    sq_b_nxt = '0;
    any_sat  = 1'b0;
    ctx_b_nxt = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sq_b_nxt = sq_b_nxt + SQ_W'(lane_a[i].aa);
      dot      = dot + {{(SCALAR_W-32){lane_a[i].ab[31]}}, lane_a[i].ab};
      any_sat  = any_sat | lane_a[i].sat;
      ctx_b_nxt.val[i] = lane_a[i].val;
      ctx_b_nxt.mag[i] = lane_a[i].mag;
      ctx_b_nxt.neg[i] = lane_a[i].neg;
    end
    ctx_b_nxt.cmd    = cmd_a_r;
    ctx_b_nxt.status = any_sat ? ST_SAT : ST_OK;
    if (cmd_a_r == CMD_DOT) begin
      ctx_b_nxt.scalar = dot;
    end else if (cmd_a_r == CMD_SQLEN) begin
      ctx_b_nxt.scalar = sq_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_b_r <= ctx_b_nxt;
      sq_b_r  <= sq_b_nxt;
      ctx_line_r[0] <= ctx_b_r;
      for (int k = 1; k < LINE; k++) begin
        ctx_line_r[k] <= ctx_line_r[k-1];
      end
      len_line_r[0] <= root;
      for (int k = 1; k < DIV_STEPS; k++) begin
        len_line_r[k] <= len_line_r[k-1];
      end
    end
  end

  va4n_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .sq   (sq_b_r),
    .root (root)
  );

  always_comb begin
    len_in[0] = root;
    for (int k = 1; k < DIV_STEPS; k++) begin
      len_in[k] = len_line_r[k-1];
    end
  end

  assign ctx_end = ctx_line_r[LINE-1];
  assign len_end = len_line_r[DIV_STEPS-1];

  always_comb begin
    logic [NUM_LANES-1:0][COMP_W-1:0] lanes;
    logic [SCALAR_W-1:0]              scalar;
    logic [STATUS_W-1:0]              status;
    lanes  = '0;
    scalar = '0;
    status = ST_OK;
    unique case (ctx_end.cmd)
      CMD_ADD, CMD_SUB: begin
        lanes  = ctx_end.val;
        status = ctx_end.status;
      end
      CMD_DOT, CMD_SQLEN: begin
        scalar = ctx_end.scalar;
      end
      CMD_LEN: begin
        scalar = SCALAR_W'(len_end >> LEN_FRAC_DROP);
      end
      CMD_NORM: begin
        if (len_end == '0) begin
          status = ST_ZERO;
        end else begin
          for (int i = 0; i < NUM_LANES; i++) begin
            lanes[i] = ctx_end.neg[i] ? (COMP_W'(0) - COMP_W'(quo[i])) : COMP_W'(quo[i]);
          end
        end
      end
      default: begin
      end
    endcase
    out_data_nxt = {6'd0, scalar, lanes};
    out_user_nxt = status;
  end

  always_comb begin
    vld_nxt = {vld_r[VLD-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[VLD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `VA4N_ASSERT_RST(a_reset_clears, !rst_n |=> !out_tvalid, "output valid after reset")
  `VA4N_ASSERT(a_status_code, out_tvalid |-> out_tuser != 2'd3, "undefined status code")
  `VA4N_ASSERT(a_zero_len_lanes, (out_tvalid && out_tuser == ST_ZERO) |-> out_tdata[63:0] == 64'd0, "lanes not zero on zero length")
  `VA4N_ASSERT(a_pipe_moves, (vld_r[VLD-1] && adv) |=> out_tvalid, "result lost at output register")

endmodule

// ===== tb/vector4_alu_normalise_unit_checker.sv =====
// Checker for the vector ALU and normalise unit: watches both streams,
// predicts each result from the accepted input item and compares field by field.
// Depends on va4n_pkg.
module vector4_alu_normalise_unit_checker
  import va4n_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic [1:0]   out_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [3:0][15:0] lanes;
    logic [33:0]      scalar;
    logic [1:0]       status;
  } vec_result_t;

  vec_result_t expected_results[$];
  string       lane_name [4] = '{"out_x", "out_y", "out_z", "out_w"};

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic vec_result_t predict_vector_op(logic [2:0] cmd, logic [135:0] d);
    vec_result_t r;
    logic signed [63:0] a [4];
    logic signed [63:0] b [4];
    logic signed [63:0] v;
    logic [63:0] sq, acc, len, mag, q;
    int n;
    r = '0;
    n = d[2:0];
    if (n < 2) n = 2;
    if (n > NUM_LANES) n = NUM_LANES;
    for (int i = 0; i < 4; i++) begin
      a[i] = $signed(d[3+16*i +: 16]);
      b[i] = $signed(d[67+16*i +: 16]);
    end
    sq = 0;
    for (int i = 0; i < n; i++) sq = sq + a[i] * a[i];
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        for (int i = 0; i < n; i++) begin
          v = (cmd == CMD_ADD) ? a[i] + b[i] : a[i] - b[i];
          if (v > 32767) begin
            v = 32767;
            r.status = ST_SAT;
          end else if (v < -32768) begin
            v = -32768;
            r.status = ST_SAT;
          end
          r.lanes[i] = v[15:0];
        end
      end
      CMD_DOT: begin
        acc = 0;
        for (int i = 0; i < n; i++) acc = acc + a[i] * b[i];
        r.scalar = acc[33:0];
      end
      CMD_SQLEN: r.scalar = sq[33:0];
      CMD_LEN: begin
        len = int_sqrt(sq);
        r.scalar = len[33:0];
      end
      CMD_NORM: begin
        len = int_sqrt(sq << 16);
        if (sq == 0 || len == 0) begin
          r.status = ST_ZERO;
        end else begin
          for (int i = 0; i < n; i++) begin
            mag = (a[i] < 0) ? -a[i] : a[i];
            q = (mag << 22) / len;
            v = (a[i] < 0) ? -$signed(q) : $signed(q);
            r.lanes[i] = v[15:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    vec_result_t exp_r;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_vector_op(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          for (int i = 0; i < 4; i++)
            if (out_tdata[16*i +: 16] !== exp_r.lanes[i]) begin
              $error("%s: expected %h, actual %h", lane_name[i], exp_r.lanes[i],
                     out_tdata[16*i +: 16]);
              errs++;
            end
          if (out_tdata[97:64] !== exp_r.scalar) begin
            $error("scalar_out: expected %h, actual %h", exp_r.scalar, out_tdata[97:64]);
            errs++;
          end
          if (out_tuser !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_tuser);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
    pending <= expected_results.size();
  end

endmodule

// ===== tb/tb_vector4_alu_normalise_unit.sv =====
// Top of the vector ALU and normalise unit testbench: clock, reset, stimulus
// and verdict. Depends on va4n_pkg, the block and its checker.
module tb_vector4_alu_normalise_unit;
  import va4n_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;
  int           fail_count;
  int           pending;
  int           idle_cycles;
  bit           hold_sink;

  vector4_alu_normalise_unit u_dut (.*);

  vector4_alu_normalise_unit_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [15:0] comp_value();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // Valid stays high between back-to-back items and drops only ahead of a gap.
  task automatic send_item(logic [2:0] cmd, logic [2:0] dims, logic [3:0][15:0] a,
                           logic [3:0][15:0] b, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'd0, b, a, dims};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(bit no_gap);
    logic [3:0][15:0] a, b;
    logic [2:0] dims;
    for (int i = 0; i < 4; i++) begin
      a[i] = comp_value();
      b[i] = comp_value();
    end
    dims = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(2, 4));
    if ($urandom_range(0, 15) == 0) a = '0;
    send_item(3'($urandom), dims, a, b, no_gap);
  endtask

  // Sink readiness: random gaps, plus one long hold-off on request.
  initial begin
    bit held;
    held = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink && !held) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if ($urandom_range(0, 30) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 50)) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0][15:0] a, b;
    int cmd_i;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = CMD_CLEAR;
    hold_sink = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: every operation at the extremes, zero vector, odd dims values.
    for (cmd_i = 0; cmd_i < 8; cmd_i++) begin
      a = {4{16'h7fff}};
      b = {4{16'h7fff}};
      send_item(3'(cmd_i), 3'd4, a, b, 0);
      a = {4{16'h8000}};
      send_item(3'(cmd_i), 3'd3, a, b, 0);
    end
    send_item(CMD_SUB, 3'd2, {4{16'h8000}}, {4{16'h7fff}}, 0);
    send_item(CMD_NORM, 3'd4, '0, '0, 0);
    send_item(CMD_NORM, 3'd0, {16'h0, 16'h0, 16'h0, 16'h0001}, '0, 0);
    send_item(CMD_LEN, 3'd7, {4{16'hffff}}, '0, 0);
    send_item(CMD_ADD, 3'd1, {16'h1, 16'h2, 16'h3, 16'h4}, {4{16'h1}}, 0);
    send_item(CMD_NORM, 3'd2, {16'h0, 16'h0, 16'h0300, 16'h0400}, '0, 0);

    for (int n = 0; n < 460; n++) begin
      if (n == 150) begin
        hold_sink = 1;
        for (int k = 0; k < 120; k++) send_random(1);
      end
      if (n == 300) begin
        in_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      send_random(0);
    end

    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/va4n_pkg.sv
rtl/core/va4n_lane.sv
rtl/core/va4n_sqrt.sv
rtl/core/va4n_div.sv
rtl/core/vector4_alu_normalise_unit.sv
tb/vector4_alu_normalise_unit_checker.sv
tb/tb_vector4_alu_normalise_unit.sv
